### hw/rtl/brf_pkg.sv
// Shared types and constants for the byte ring FIFO with reserve.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package brf_pkg;

  localparam int DEPTH_DEFAULT  = 1024;
  localparam int CAPACITY_RESET = 1024;
  localparam int RESERVE_RESET  = 4;

  localparam int OP_W    = 2;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 11;
  localparam int RSV_W   = 4;
  localparam int CFG_W   = 11;
  localparam int REG_W   = 1;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH      = 2'd0,
    OP_POP       = 2'd1,
    OP_DISCARD   = 2'd2,
    OP_OVERWRITE = 2'd3
  } op_t;

  typedef enum logic [REG_W-1:0] {
    REG_CAPACITY = 1'b0,
    REG_RESERVE  = 1'b1
  } reg_t;

endpackage

`default_nettype wire

### hw/rtl/brf_ifs.sv
// Valid/ready channel interfaces for request and response items.
// Depends on brf_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface brf_req_if;
  import brf_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [BYTE_W-1:0]  data_byte;
  logic [COUNT_W-1:0] discard_count;

  modport source (output valid, operation, data_byte, discard_count, input ready);
  modport sink   (input valid, operation, data_byte, discard_count, output ready);
endinterface

interface brf_rsp_if;
  import brf_pkg::*;
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  read_byte;
  logic               read_valid;
  logic [COUNT_W-1:0] moved;
  logic               dropped_oldest;
  logic [COUNT_W-1:0] data_count;
  logic [COUNT_W-1:0] free_count;

  modport source (output valid, read_byte, read_valid, moved, dropped_oldest,
                  data_count, free_count, input ready);
  modport sink   (input valid, read_byte, read_valid, moved, dropped_oldest,
                  data_count, free_count, output ready);
endinterface

`default_nettype wire

### hw/rtl/byte_ring_fifo_with_reserve.sv
// Path: an accepted item's result passes the stage 1 register, then the output register.
// Throughput: one item per cycle unless the output stalls; index updates are done at
// acceptance; only pop data comes from the RAM's registered read port the next cycle.
// Reset: indices cleared, capacity min(1024, DEPTH), reserve 4; storage is not cleared.
// Depends on brf_pkg and brf_ifs.
`timescale 1ns / 1ps
`default_nettype none

module byte_ring_fifo_with_reserve #(
  parameter int DEPTH = brf_pkg::DEPTH_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [brf_pkg::REG_W-1:0] cfg_index,
  input  wire logic [brf_pkg::CFG_W-1:0] cfg_wdata,
  brf_req_if.sink                        req,
  brf_rsp_if.source                      rsp
);
  import brf_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CAPW = $clog2(DEPTH + 1);
  localparam logic [CAPW-1:0] CAP_RESET =
    CAPW'((CAPACITY_RESET > DEPTH) ? DEPTH : CAPACITY_RESET);

  logic [BYTE_W-1:0] storage [DEPTH];
  logic [BYTE_W-1:0] mem_q;

  logic [AW-1:0]    wr_idx, rd_idx;
  logic [CAPW-1:0]  cap;
  logic [RSV_W-1:0] reserve;

  // stage 1: result waiting for the RAM read data
  logic               s1_valid;
  logic               s1_pop;
  logic [COUNT_W-1:0] s1_moved;
  logic               s1_dropped;
  logic [CAPW-1:0]    s1_count;

  logic out_adv, s1_adv, accept;
  assign out_adv   = !rsp.valid || rsp.ready;
  assign s1_adv    = s1_valid && out_adv;
  assign req.ready = !s1_valid || out_adv;
  assign accept    = req.valid && req.ready;

  // current occupancy
  logic [CAPW-1:0] w_e, r_e, count, raw, rsv_e, push_thr;
  assign w_e   = CAPW'(wr_idx);
  assign r_e   = CAPW'(rd_idx);
  assign count = (w_e >= r_e) ? (w_e - r_e) : (cap - (r_e - w_e));
  assign raw   = cap - count;
  assign rsv_e = CAPW'(reserve);
  assign push_thr = (reserve == '0) ? CAPW'(1) : rsv_e;

  logic [CAPW-1:0] w_inc, r_inc;
  logic [AW-1:0]   w_adv, r_adv;
  assign w_inc = w_e + CAPW'(1);
  assign r_inc = r_e + CAPW'(1);
  assign w_adv = (w_inc >= cap) ? '0 : w_inc[AW-1:0];
  assign r_adv = (r_inc >= cap) ? '0 : r_inc[AW-1:0];

  // discard
  logic [CAPW-1:0] disc_n;
  logic [CAPW:0]   r_sum, r_wrap;
  assign disc_n = (32'(req.discard_count) < 32'(count)) ? CAPW'(req.discard_count) : count;
  assign r_sum  = {1'b0, r_e} + {1'b0, disc_n};
  assign r_wrap = (r_sum >= {1'b0, cap}) ? (r_sum - {1'b0, cap}) : r_sum;

  // decode
  op_t             op;
  logic            nonempty, drop, push_ok, pop_ok;
  logic [CAPW-1:0] raw1;
  logic [AW-1:0]   wr_next, rd_next;
  logic [CAPW-1:0] count_next;
  logic [COUNT_W-1:0] moved_next;

  assign op       = op_t'(req.operation);
  assign nonempty = (count != '0);

  always_comb begin
    drop       = 1'b0;
    pop_ok     = 1'b0;
    raw1       = raw;
    push_ok    = 1'b0;
    wr_next    = wr_idx;
    rd_next    = rd_idx;
    count_next = count;
    moved_next = '0;
    case (op)
      OP_PUSH: begin
        push_ok    = (raw > push_thr);
        wr_next    = push_ok ? w_adv : wr_idx;
        count_next = count + CAPW'(push_ok);
        moved_next = COUNT_W'(push_ok);
      end
      OP_POP: begin
        pop_ok     = nonempty;
        rd_next    = pop_ok ? r_adv : rd_idx;
        count_next = count - CAPW'(pop_ok);
        moved_next = COUNT_W'(pop_ok);
      end
      OP_DISCARD: begin
        rd_next    = r_wrap[AW-1:0];
        count_next = count - disc_n;
        moved_next = COUNT_W'(disc_n);
      end
      OP_OVERWRITE: begin
        drop       = nonempty && ({1'b0, raw} <= ({1'b0, rsv_e} + (CAPW+1)'(1)));
        raw1       = raw + CAPW'(drop);
        push_ok    = (raw1 > push_thr);
        rd_next    = drop ? r_adv : rd_idx;
        wr_next    = push_ok ? w_adv : wr_idx;
        count_next = count - CAPW'(drop) + CAPW'(push_ok);
        moved_next = COUNT_W'(push_ok);
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  // storage RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept && push_ok) begin
      storage[wr_idx] <= req.data_byte;
    end
    if (accept && pop_ok) begin
      mem_q <= storage[rd_idx];
    end
  end

  // indices and configuration
  logic [CAPW-1:0] cap_wr;
  always_comb begin
    if (cfg_wdata == '0) begin
      cap_wr = CAPW'(1);
    end else if (32'(cfg_wdata) > DEPTH) begin
      cap_wr = CAPW'(DEPTH);
    end else begin
      cap_wr = CAPW'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx  <= '0;
      rd_idx  <= '0;
      cap     <= CAP_RESET;
      reserve <= RSV_W'(RESERVE_RESET);
    end else if (cfg_we) begin
      case (reg_t'(cfg_index))
        REG_CAPACITY: begin
          cap    <= cap_wr;
          wr_idx <= '0;
          rd_idx <= '0;
        end
        REG_RESERVE: begin
          reserve <= cfg_wdata[RSV_W-1:0];
        end
        default: begin
          reserve <= reserve;
        end
      endcase
    end else if (accept) begin
      wr_idx <= wr_next;
      rd_idx <= rd_next;
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_pop     <= pop_ok;
      s1_moved   <= moved_next;
      s1_dropped <= drop;
      s1_count   <= count_next;
    end
  end

  // output register
  logic [CAPW-1:0] raw2, free2;
  assign raw2  = cap - s1_count;
  assign free2 = (raw2 > rsv_e) ? (raw2 - rsv_e) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_adv) begin
      rsp.valid <= s1_valid;
    end
    if (s1_adv) begin
      rsp.read_byte      <= s1_pop ? mem_q : '0;
      rsp.read_valid     <= s1_pop;
      rsp.moved          <= s1_moved;
      rsp.dropped_oldest <= s1_dropped;
      rsp.data_count     <= COUNT_W'(s1_count);
      rsp.free_count     <= COUNT_W'(free2);
    end
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (w_e < cap) && (r_e < cap))
    else $error("index beyond capacity");

  a_never_full: assert property (@(posedge clk) disable iff (rst)
    count < cap)
    else $error("occupancy reached capacity");

  a_rdata_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_pop && !out_adv |=> $stable(mem_q))
    else $error("read data lost while stalled");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    accept && push_ok |-> raw1 >= CAPW'(2))
    else $error("push without room");
`endif

endmodule

`default_nettype wire
